// ----- rtl/luma_histogram_scene_change_unit_macros.svh -----
// assertion macros shared by the histogram checker
`ifndef LUMA_HISTOGRAM_SCENE_CHANGE_UNIT_MACROS_SVH
`define LUMA_HISTOGRAM_SCENE_CHANGE_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define LHSC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define LHSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/lhsc_pkg.sv -----
// types and constants of the luma histogram scene change unit
package lhsc_pkg;

  localparam int LUMA_W         = 8;
  localparam int BIN_COUNT      = 16;
  localparam int BIN_IDX_W      = 4;
  localparam int BIN_W          = 19;
  localparam int DIST_W         = 20;
  localparam int LUMA_BIN_SHIFT = 4;
  localparam int WIDTH_REG_W    = 13;
  localparam int THRESH_W       = 20;
  localparam int CFG_DATA_W     = 20;
  localparam int CFG_IDX_W      = 1;

  localparam logic [BIN_W-1:0]       BIN_MAX         = '1;
  localparam logic [DIST_W-1:0]      DIST_MAX        = '1;
  localparam logic [WIDTH_REG_W-1:0] RESET_WIDTH     = 13'd640;
  localparam logic [THRESH_W-1:0]    RESET_THRESHOLD = 20'd30000;
  localparam logic [BIN_IDX_W-1:0]   LAST_BIN        = BIN_IDX_W'(BIN_COUNT - 1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANGE_THRESHOLD = 1'd1;

  typedef struct packed {
    logic [LUMA_W-1:0] luma;
    logic              end_of_frame;
  } in_item_t;

  typedef struct packed {
    logic              scene_cut;
    logic [DIST_W-1:0] distance;
    logic              compared;
  } out_item_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic                 pix_en;
    logic                 eof_en;
    logic                 step_en;
    logic                 step_first;
    logic                 step_last;
    logic [BIN_IDX_W-1:0] step_idx;
  } ctrl_cmd_t;

endpackage

// ----- rtl/lhsc_ctrl.sv -----
// controller: pixel acceptance, end-of-frame bin sweep and result handoff
module lhsc_ctrl
  import lhsc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_eof,
  input  logic       out_stall,
  output logic       in_stall,
  output logic       out_valid,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_RUN   = 2'b01,
    ST_SWEEP = 2'b10
  } state_t;

  state_t               state_r, state_nxt;
  logic [BIN_IDX_W-1:0] idx_r, idx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 accept;
  logic                 out_free;
  logic                 step;
  logic                 in_sweep;

  assign in_sweep = (state_r == ST_SWEEP);
  assign accept   = !in_sweep && in_valid;
  assign out_free = !out_valid_r || !out_stall;
  // the last step writes the result, so it waits for a free slot
  assign step     = in_sweep && ((idx_r != LAST_BIN) || out_free);

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_RUN: begin
        if (accept && in_eof) begin
          state_nxt = ST_SWEEP;
          idx_nxt   = '0;
        end
      end
      ST_SWEEP: begin
        if (step) begin
          idx_nxt = idx_r + BIN_IDX_W'(1);
          if (idx_r == LAST_BIN) begin
            state_nxt     = ST_RUN;
            out_valid_nxt = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = in_sweep;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.pix_en     = accept;
    cmd.eof_en     = accept && in_eof;
    cmd.step_en    = step;
    cmd.step_first = (idx_r == '0);
    cmd.step_last  = (idx_r == LAST_BIN);
    cmd.step_idx   = idx_r;
  end

endmodule

// ----- rtl/lhsc_dpath.sv -----
// datapath: position counters, histogram bins, distance accumulator, result register
module lhsc_dpath
  import lhsc_pkg::*;
#(
  parameter int MAX_WIDTH   = 4096,
  parameter int MAX_HEIGHT  = 4096,
  parameter int SAMPLE_STEP = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  in_item_t               in_data,
  input  ctrl_cmd_t              cmd,
  output out_item_t              out_data
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int PH_W  = (SAMPLE_STEP > 1) ? $clog2(SAMPLE_STEP) : 1;
  localparam int EW    = WIDTH_REG_W + 1;

  localparam logic [EW-1:0]    MAX_W_E  = EW'(MAX_WIDTH);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAX_HEIGHT - 1);
  localparam logic [PH_W-1:0]  PH_LAST  = PH_W'(SAMPLE_STEP - 1);

  // configuration
  logic [WIDTH_REG_W-1:0] frame_width_r;
  logic [THRESH_W-1:0]    thresh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r <= RESET_WIDTH;
      thresh_r      <= RESET_THRESHOLD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:      frame_width_r <= cfg_data[WIDTH_REG_W-1:0];
        REG_CHANGE_THRESHOLD: thresh_r      <= cfg_data[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // raster position, with sampling phases kept beside the counters
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [PH_W-1:0]  col_ph_r, col_ph_nxt;
  logic [PH_W-1:0]  row_ph_r, row_ph_nxt;
  logic [EW-1:0]    eff_width;
  logic [EW-1:0]    col_plus;
  logic             row_end;
  logic             sample;

  always_comb begin
    if (frame_width_r == '0) begin
      eff_width = EW'(1);
    end else if (EW'(frame_width_r) > MAX_W_E) begin
      eff_width = MAX_W_E;
    end else begin
      eff_width = EW'(frame_width_r);
    end
  end

  assign col_plus = EW'(col_r) + EW'(1);
  assign row_end  = (col_plus >= eff_width);
  assign sample   = (col_ph_r == '0) && (row_ph_r == '0);

  always_comb begin
    col_nxt    = col_r;
    row_nxt    = row_r;
    col_ph_nxt = col_ph_r;
    row_ph_nxt = row_ph_r;
    if (cmd.eof_en) begin
      col_nxt    = '0;
      row_nxt    = '0;
      col_ph_nxt = '0;
      row_ph_nxt = '0;
    end else if (cmd.pix_en) begin
      if (row_end) begin
        col_nxt    = '0;
        col_ph_nxt = '0;
        if (row_r < ROW_LAST) begin
          row_nxt    = row_r + ROW_W'(1);
          row_ph_nxt = (row_ph_r == PH_LAST) ? '0 : row_ph_r + PH_W'(1);
        end
      end else begin
        col_nxt    = col_plus[COL_W-1:0];
        col_ph_nxt = (col_ph_r == PH_LAST) ? '0 : col_ph_r + PH_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      col_ph_r <= '0;
      row_ph_r <= '0;
    end else begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      col_ph_r <= col_ph_nxt;
      row_ph_r <= row_ph_nxt;
    end
  end

  // histogram bins, one shared address for increment and sweep
  logic [BIN_W-1:0]     cur_r  [BIN_COUNT];
  logic [BIN_W-1:0]     prev_r [BIN_COUNT];
  logic [BIN_IDX_W-1:0] bin_idx;
  logic [BIN_IDX_W-1:0] rd_idx;
  logic [BIN_W-1:0]     cur_rd;
  logic [BIN_W-1:0]     prev_rd;
  logic                 cur_we;
  logic [BIN_W-1:0]     cur_wd;

  assign bin_idx = BIN_IDX_W'(in_data.luma >> LUMA_BIN_SHIFT);
  assign rd_idx  = cmd.step_en ? cmd.step_idx : bin_idx;
  assign cur_rd  = cur_r[rd_idx];
  assign prev_rd = prev_r[cmd.step_idx];
  assign cur_we  = cmd.step_en || (cmd.pix_en && sample && (cur_rd != BIN_MAX));
  assign cur_wd  = cmd.step_en ? '0 : cur_rd + BIN_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BIN_COUNT; i++) begin
        cur_r[i]  <= '0;
        prev_r[i] <= '0;
      end
    end else begin
      if (cur_we) begin
        cur_r[rd_idx] <= cur_wd;
      end
      if (cmd.step_en) begin
        prev_r[cmd.step_idx] <= cur_rd;
      end
    end
  end

  // saturating L1 distance, one bin per step
  logic [DIST_W-1:0] acc_r, acc_nxt;
  logic [BIN_W-1:0]  diff;
  logic [DIST_W-1:0] acc_base;
  logic [DIST_W:0]   sum;
  logic              have_prev_r;
  out_item_t         out_r;

  assign diff     = (cur_rd >= prev_rd) ? (cur_rd - prev_rd) : (prev_rd - cur_rd);
  assign acc_base = cmd.step_first ? '0 : acc_r;
  assign sum      = (DIST_W + 1)'(acc_base) + (DIST_W + 1)'(diff);
  assign acc_nxt  = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.step_en) begin
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
    end else if (cmd.step_en && cmd.step_last) begin
      have_prev_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step_en && cmd.step_last) begin
      out_r.compared  <= have_prev_r;
      out_r.distance  <= have_prev_r ? acc_nxt : '0;
      out_r.scene_cut <= have_prev_r && (acc_nxt > thresh_r);
    end
  end

  assign out_data = out_r;

endmodule

// ----- rtl/luma_histogram_scene_change_unit.sv -----
// top level of the luma histogram scene change unit
//
//  channel | direction | handshake          | beat payload
//  --------+-----------+--------------------+----------------------------------------
//  in_     | input     | in_valid/in_stall  | in_item_t: luma, end_of_frame
//  out_    | output    | out_valid/out_stall| out_item_t: scene_cut, distance, compared
//  cfg_    | input     | cfg_we             | cfg_index, cfg_data (no read-back)
//
// one pixel beat per cycle while a frame streams in
// the end-of-frame beat starts a sweep over the bins, one bin per cycle but for
//   the wait below, via one subtractor and accumulator; in_stall is high meanwhile
// the last sweep step waits while an earlier result is still stalled on out_
// pixels keep flowing while a finished result waits on out_stall
// rst_n is synchronous and active low; bins and counters clear at once
module luma_histogram_scene_change_unit
  import lhsc_pkg::*;
#(
  parameter int MAX_WIDTH   = 4096,
  parameter int MAX_HEIGHT  = 4096,
  parameter int SAMPLE_STEP = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // pixel beats
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  // one result beat per frame
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  // register writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // command bundle from controller to datapath
  ctrl_cmd_t cmd;

  // controller sequences pixel acceptance and the end-of-frame sweep
  lhsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_eof    (in_data.end_of_frame),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // datapath holds counters, bins, the accumulator and the result register
  lhsc_dpath #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .SAMPLE_STEP (SAMPLE_STEP)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/lhsc_checker.sv -----
// port-level checker for the luma histogram scene change unit, with its bind
`include "luma_histogram_scene_change_unit_macros.svh"

module lhsc_checker
  import lhsc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // a stalled result holds
  `LHSC_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_data), "stalled result changed")

  // no previous histogram means no distance and no flag
  `LHSC_ASSERT_SAME(a_first_frame, out_valid && !out_data.compared,
    (out_data.distance == '0) && !out_data.scene_cut, "uncompared result not zero")

  // a flag needs a comparison and a nonzero distance
  `LHSC_ASSERT_SAME(a_flag_valid, out_valid && out_data.scene_cut,
    out_data.compared && (out_data.distance != '0), "scene change without distance")

  // end of frame starts the bin sweep, input is held off
  `LHSC_ASSERT_NEXT(a_eof_sweep, in_valid && !in_stall && in_data.end_of_frame,
    in_stall, "no sweep after end of frame")

endmodule

bind luma_histogram_scene_change_unit lhsc_checker u_lhsc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ----- bench/tb_luma_histogram_scene_change_unit.sv -----
// self-checking bench for the luma histogram scene change unit
module tb_luma_histogram_scene_change_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import lhsc_pkg::*;

  // block parameters, passed to the dut so both sides agree
  localparam int MAX_WIDTH   = 4096;
  localparam int MAX_HEIGHT  = 4096;
  localparam int SAMPLE_STEP = 8;

  // run shape
  localparam int RANDOM_PIXELS  = 1400;
  localparam int PRESSURE_PHASE = 1;       // random phase that carries the receiver hold-off
  localparam int HOLD_CYCLES    = 400;     // receiver hold-off, long enough to back up results
  localparam int DRAIN_CYCLES   = 32;      // bin sweep plus margin
  localparam int SETTLE_MAX     = 4000;    // bound on waiting for outstanding results
  localparam int MAX_REPORTS    = 10;
  localparam int LIMIT_NS       = 3_000_000;
  // window of each side's cycle count with no idling at all
  localparam int CALM_FROM      = 600;
  localparam int CALM_TO        = 1400;

  localparam out_item_t NO_VERDICT = '0;

  // one pixel beat waiting to be offered, with an optional hand-typed verdict
  typedef struct packed {
    in_item_t  px;
    logic      typed;
    out_item_t want;
  } pix_beat_t;

  // directed table: a run of identical pixels, or a register write
  typedef enum logic {ROW_PIXELS, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;     // register index, ignored on pixel rows
    logic [CFG_DATA_W-1:0] val;     // luma on pixel rows, write data otherwise
    logic                  eof;     // end-of-frame on the last pixel of the run
    logic [7:0]            reps;
    logic                  typed;
    out_item_t             want;
  } stim_row_t;

  // verdicts typed in here are plain to read: the first frame never compares,
  // single-sample frames move one count between two bins, and the threshold
  // is strict (distance equal to it does not flag)
  localparam stim_row_t DIRECTED [16] = '{
    // kind       idx                   val          eof   reps  typed want
    '{ROW_PIXELS, REG_FRAME_WIDTH,      20'h00,      1'b0, 8'd1, 1'b0, NO_VERDICT},
    '{ROW_PIXELS, REG_FRAME_WIDTH,      20'hFF,      1'b1, 8'd2, 1'b1, '{1'b0, 20'd0, 1'b0}},
    '{ROW_PIXELS, REG_FRAME_WIDTH,      20'hFF,      1'b1, 8'd1, 1'b1, '{1'b0, 20'd2, 1'b1}},
    '{ROW_WRITE,  REG_CHANGE_THRESHOLD, 20'd0,       1'b0, 8'd0, 1'b0, NO_VERDICT},
    '{ROW_PIXELS, REG_FRAME_WIDTH,      20'h7F,      1'b1, 8'd1, 1'b1, '{1'b1, 20'd2, 1'b1}},
    '{ROW_PIXELS, REG_FRAME_WIDTH,      20'h70,      1'b1, 8'd1, 1'b1, '{1'b0, 20'd0, 1'b1}},
    '{ROW_WRITE,  REG_CHANGE_THRESHOLD, 20'd2,       1'b0, 8'd0, 1'b0, NO_VERDICT},
    '{ROW_PIXELS, REG_FRAME_WIDTH,      20'h00,      1'b1, 8'd1, 1'b1, '{1'b0, 20'd2, 1'b1}},
    '{ROW_WRITE,  REG_CHANGE_THRESHOLD, 20'd1,       1'b0, 8'd0, 1'b0, NO_VERDICT},
    '{ROW_PIXELS, REG_FRAME_WIDTH,      20'h80,      1'b1, 8'd1, 1'b1, '{1'b1, 20'd2, 1'b1}},
    // zero width acts as one: every pixel is a new row, row 8 samples again
    '{ROW_WRITE,  REG_FRAME_WIDTH,      20'd0,       1'b0, 8'd0, 1'b0, NO_VERDICT},
    '{ROW_PIXELS, REG_FRAME_WIDTH,      20'h35,      1'b1, 8'd9, 1'b0, NO_VERDICT},
    // bits above the 13-bit width register are dropped
    '{ROW_WRITE,  REG_FRAME_WIDTH,      20'hFE009,   1'b0, 8'd0, 1'b0, NO_VERDICT},
    '{ROW_PIXELS, REG_FRAME_WIDTH,      20'h11,      1'b0, 8'd3, 1'b0, NO_VERDICT},
    // width cut below the current column: the row ends on the next pixel
    '{ROW_WRITE,  REG_FRAME_WIDTH,      20'd1,       1'b0, 8'd0, 1'b0, NO_VERDICT},
    '{ROW_PIXELS, REG_FRAME_WIDTH,      20'h22,      1'b1, 8'd9, 1'b0, NO_VERDICT}
  };

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  luma_histogram_scene_change_unit #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .SAMPLE_STEP(SAMPLE_STEP)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // pixel beats still to be offered, and verdicts still to arrive
  pix_beat_t pixel_queue[$];
  out_item_t pending_verdicts[$];
  pix_beat_t beat_cur = '0;    // beat currently on in_data
  int        mismatches = 0;

  // our own copy of the histogram state and registers
  logic [BIN_W-1:0]       cur_bins  [BIN_COUNT];
  logic [BIN_W-1:0]       prev_bins [BIN_COUNT];
  logic                   have_prev;
  int                     col_pos;
  int                     row_pos;
  logic [WIDTH_REG_W-1:0] width_reg;
  logic [THRESH_W-1:0]    thresh_reg;

  // receiver hold-off request, raised once by the sequence at a falling edge
  logic hold_req = 1'b0;

  // advance the histogram by one accepted pixel; returns 1 when a verdict is due
  function automatic logic histogram_step(input in_item_t px, output out_item_t verdict);
    int                   eff;
    int unsigned          l1_sum;
    logic [BIN_IDX_W-1:0] bin;
    verdict = NO_VERDICT;
    // zero width acts as one, anything past the line buffer as the maximum
    if (width_reg == '0)
      eff = 1;
    else if (int'(width_reg) > MAX_WIDTH)
      eff = MAX_WIDTH;
    else
      eff = int'(width_reg);
    // sample grid: column and row both multiples of the step
    if (col_pos % SAMPLE_STEP == 0 && row_pos % SAMPLE_STEP == 0) begin
      bin = px.luma[LUMA_W-1 -: BIN_IDX_W];
      if (cur_bins[bin] != BIN_MAX)
        cur_bins[bin] = cur_bins[bin] + 1'b1;
    end
    // a row ends once the next column reaches or passes the width in force
    if (col_pos + 1 >= eff) begin
      col_pos = 0;
      if (row_pos < MAX_HEIGHT - 1)
        row_pos++;
    end else begin
      col_pos++;
    end
    if (!px.end_of_frame)
      return 1'b0;
    l1_sum = 0;
    if (have_prev) begin
      for (int i = 0; i < BIN_COUNT; i++)
        l1_sum += (cur_bins[i] >= prev_bins[i]) ? cur_bins[i] - prev_bins[i]
                                                : prev_bins[i] - cur_bins[i];
      if (l1_sum > DIST_MAX)
        l1_sum = DIST_MAX;
    end
    verdict.compared  = have_prev;
    verdict.distance  = l1_sum[DIST_W-1:0];
    verdict.scene_cut = have_prev && (l1_sum > thresh_reg);
    // histogram rolls over to previous, counters restart for the next frame
    prev_bins = cur_bins;
    foreach (cur_bins[i])
      cur_bins[i] = '0;
    have_prev = 1'b1;
    col_pos   = 0;
    row_pos   = 0;
    return 1'b1;
  endfunction

  // sender: one beat per accepted handshake, random idles outside the calm window
  int tx_cyc = 0;
  always @(posedge clk) begin : drive_pixels
    pix_beat_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      tx_cyc++;
      // a stalled beat holds; otherwise pick the next one or idle
      if (!in_valid || !in_stall) begin
        if (pixel_queue.size() != 0 &&
            ((tx_cyc >= CALM_FROM && tx_cyc < CALM_TO) || $urandom_range(99) >= 23)) begin
          nxt = pixel_queue.pop_front();
          in_valid <= 1'b1;
          in_data  <= nxt.px;
          beat_cur <= nxt;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls, a calm window, and one long hold-off so the
  // result side backs up into the pixel side
  int rx_cyc    = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      rx_cyc++;
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !(rx_cyc >= CALM_FROM && rx_cyc < CALM_TO) && ($urandom_range(99) < 23);
      end
    end
  end

  // predict on every accepted pixel beat, check every accepted result beat
  always @(posedge clk) begin : check_results
    out_item_t fresh;
    out_item_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        if (histogram_step(in_data, fresh))
          pending_verdicts.push_back(beat_cur.typed ? beat_cur.want : fresh);
      end
      if (out_valid && !out_stall) begin
        if (pending_verdicts.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch at %0t: result beat with none pending: chg=%b dist=%0d cmp=%b",
                     $realtime, out_data.scene_cut, out_data.distance, out_data.compared);
        end else begin
          want = pending_verdicts.pop_front();
          if (out_data.scene_cut !== want.scene_cut ||
              out_data.distance !== want.distance ||
              out_data.compared !== want.compared) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display({"mismatch at %0t: expected chg=%b dist=%0d cmp=%b, ",
                        "got chg=%b dist=%0d cmp=%b"},
                       $realtime, want.scene_cut, want.distance, want.compared,
                       out_data.scene_cut, out_data.distance, out_data.compared);
          end
        end
      end
    end
  end

  task automatic push_pixel(input logic [LUMA_W-1:0] luma, input logic eof,
                            input logic typed, input out_item_t want);
    pix_beat_t b;
    b.px.luma         = luma;
    b.px.end_of_frame = eof;
    b.typed           = typed;
    b.want            = want;
    pixel_queue.push_back(b);
  endtask

  // one frame of random luma, either spread over the range or clustered
  // near one level; an open frame leaves the last pixel unmarked
  task automatic push_frame(input int len, input bit close);
    int base;
    int lv;
    base = $urandom_range(1) ? int'($urandom_range(255)) : -1;
    for (int i = 0; i < len; i++) begin
      lv = (base < 0) ? int'($urandom_range(255)) : base + int'($urandom_range(40));
      if (lv > 255)
        lv = 255;
      push_pixel(lv[LUMA_W-1:0], close && (i == len - 1), 1'b0, NO_VERDICT);
    end
  endtask

  // wait for all beats to go in and all verdicts to come out, then let the
  // bin sweep finish; called at a falling edge and returns at one
  task automatic settle();
    int n;
    n = 0;
    while (pixel_queue.size() != 0 || in_valid)
      @(negedge clk);
    while (pending_verdicts.size() != 0 && n < SETTLE_MAX) begin
      @(negedge clk);
      n++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // register write, only ever issued while the block is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_FRAME_WIDTH)
      width_reg = val[WIDTH_REG_W-1:0];
    else
      thresh_reg = val[THRESH_W-1:0];
    @(negedge clk);
  endtask

  initial begin : sequence_run
    stim_row_t             row;
    logic [CFG_DATA_W-1:0] wval;
    int                    phase;
    int                    rand_pixels;
    int                    nframes;
    int                    len;

    // state after reset
    foreach (cur_bins[i]) begin
      cur_bins[i]  = '0;
      prev_bins[i] = '0;
    end
    have_prev  = 1'b0;
    col_pos    = 0;
    row_pos    = 0;
    width_reg  = RESET_WIDTH;
    thresh_reg = RESET_THRESHOLD;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    for (int k = 0; k < $size(DIRECTED); k++) begin
      row = DIRECTED[k];
      if (row.kind == ROW_WRITE) begin
        settle();
        write_reg(row.idx, row.val);
      end else begin
        for (int r = 0; r < int'(row.reps); r++)
          push_pixel(row.val[LUMA_W-1:0], row.eof && (r == int'(row.reps) - 1),
                     row.typed, row.want);
      end
    end
    settle();

    // random phases: settings change between phases, sometimes mid-frame
    phase       = 0;
    rand_pixels = 0;
    while (rand_pixels < RANDOM_PIXELS) begin
      if ($urandom_range(1)) begin
        case ($urandom_range(9))
          0:          wval = '0;
          1:          wval = 20'd1;
          2, 3, 4, 5: wval = CFG_DATA_W'($urandom_range(16, 2));
          6:          wval = CFG_DATA_W'($urandom_range(64, 17));
          7:          wval = 20'd4096;
          8:          wval = 20'd8191;
          default:    wval = CFG_DATA_W'($urandom_range(8191));
        endcase
        write_reg(REG_FRAME_WIDTH, wval);
      end
      if ($urandom_range(1)) begin
        case ($urandom_range(7))
          0:       wval = '0;
          1:       wval = 20'd524288;
          2:       wval = '1;
          3:       wval = CFG_DATA_W'($urandom);
          default: wval = CFG_DATA_W'($urandom_range(6));
        endcase
        write_reg(REG_CHANGE_THRESHOLD, wval);
      end

      if (phase == PRESSURE_PHASE) begin
        // receiver holds off while short frames keep coming
        hold_req = 1'b1;
        for (int f = 0; f < 30; f++) begin
          len = $urandom_range(3, 1);
          push_frame(len, 1'b1);
          rand_pixels += len;
        end
      end else begin
        nframes = $urandom_range(6, 1);
        for (int f = 0; f < nframes; f++) begin
          len = ($urandom_range(99) < 80) ? $urandom_range(40, 1) : $urandom_range(160, 41);
          // the last frame of a phase is sometimes left open
          push_frame(len, (f != nframes - 1) || ($urandom_range(3) != 0));
          rand_pixels += len;
        end
      end
      settle();
      phase++;
    end

    settle();
    if (pending_verdicts.size() != 0) begin
      mismatches += pending_verdicts.size();
      $display("mismatch: %0d result beats never arrived", pending_verdicts.size());
    end
    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // hard limit on the whole run
  initial begin
    #(LIMIT_NS);
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/lhsc_pkg.sv
rtl/lhsc_ctrl.sv
rtl/lhsc_dpath.sv
rtl/luma_histogram_scene_change_unit.sv
rtl/lhsc_checker.sv
bench/tb_luma_histogram_scene_change_unit.sv
